// ----- rtl/vme_pkg.sv -----
// ----------------------------------------------------------------------------
// vme_pkg
// shared widths, register indexes and item codes of the volume edge marker
// ----------------------------------------------------------------------------
package vme_pkg;

  localparam int WORD_W      = 32;
  localparam int DIM_XY_W    = 9;
  localparam int DIM_Z_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int DEF_MAX_ROW  = 256;
  localparam int DEF_MAX_ROWS = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_X     = 3'd0,
    REG_DIM_Y     = 3'd1,
    REG_DIM_Z     = 3'd2,
    REG_ON_VALUE  = 3'd3,
    REG_OFF_VALUE = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    FUNC_VOXEL = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_t;

endpackage

// ----- rtl/vme_if.sv -----
// ----------------------------------------------------------------------------
// vme channel interfaces
// valid/ready channels for voxel words in and edge words out
// ----------------------------------------------------------------------------
interface vme_in_if;
  import vme_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [WORD_W-1:0] voxel_word;
  modport source (output valid, output func, output voxel_word, input ready);
  modport sink   (input valid, input func, input voxel_word, output ready);
endinterface

interface vme_out_if;
  import vme_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] edge_word;
  logic              last_voxel;
  modport source (output valid, output edge_word, output last_voxel, input ready);
  modport sink   (input valid, input edge_word, input last_voxel, output ready);
endinterface

// ----- rtl/volume_mask_edge_marker.sv -----
// ----------------------------------------------------------------------------
// volume_mask_edge_marker
// 26-connected boundary marker for a raster-order 3-d mask volume
// ----------------------------------------------------------------------------
//  channel  | dir | payload                 | transaction
//  in_ch    | in  | func, voxel_word        | valid & ready
//  out_ch   | out | edge_word, last_voxel   | valid & ready
//  cfg      | in  | cfg_index, cfg_data     | cfg_we
//
//  one transaction per cycle unless stalled; an accepted item passes stage
//  1 registers to the output register; voxel o's result leaves with input
//  item o+D (D = dim_x*dim_y + dim_x + 1), so D flush items drain a volume
//  the plane memory and row memory each take one read and one write a cycle
//  synchronous reset clears counters, window and pipeline valids; the
//  memories are not cleared, boundary masking hides stale entries
//  after reset or a register write in_ch.ready stays low while the
//  clamped geometry settles
//  a stalled output holds the whole pipeline and drops in_ch.ready
// ----------------------------------------------------------------------------
module volume_mask_edge_marker #(
  parameter int MAX_ROW  = vme_pkg::DEF_MAX_ROW,
  parameter int MAX_ROWS = vme_pkg::DEF_MAX_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  vme_in_if.sink                        in_ch,
  vme_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [vme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vme_pkg::WORD_W-1:0]    cfg_data
);
  import vme_pkg::*;

  localparam int PDEPTH = MAX_ROW * MAX_ROWS;
  localparam int XAW    = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int YAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int XDW    = $clog2(MAX_ROW + 1);
  localparam int YDW    = $clog2(MAX_ROWS + 1);
  localparam int PDW    = $clog2(PDEPTH + 1);
  localparam int TW     = PDW + DIM_Z_W;
  localparam int PSW    = TW + 1;

  // configuration registers
  logic [DIM_XY_W-1:0] dim_x, dim_y;
  logic [DIM_Z_W-1:0]  dim_z;
  logic [WORD_W-1:0]   on_value, off_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x     <= DIM_XY_W'(1);
      dim_y     <= DIM_XY_W'(1);
      dim_z     <= DIM_Z_W'(1);
      on_value  <= '0;
      off_value <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM_X:     dim_x     <= cfg_data[DIM_XY_W-1:0];
        REG_DIM_Y:     dim_y     <= cfg_data[DIM_XY_W-1:0];
        REG_DIM_Z:     dim_z     <= cfg_data[DIM_Z_W-1:0];
        REG_ON_VALUE:  on_value  <= cfg_data;
        REG_OFF_VALUE: off_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped geometry, registered in a short chain (input held off until settled)
  logic [XDW-1:0]     dx, dx_next;
  logic [YDW-1:0]     dy, dy_next;
  logic [DIM_Z_W-1:0] dz, dz_next;
  logic [PDW-1:0]     plane;
  logic [TW-1:0]      total;
  logic [PSW-1:0]     delay;

  always_comb begin
    if (dim_x == '0) dx_next = XDW'(1);
    else if (32'(dim_x) > MAX_ROW) dx_next = XDW'(MAX_ROW);
    else dx_next = XDW'(dim_x);
    if (dim_y == '0) dy_next = YDW'(1);
    else if (32'(dim_y) > MAX_ROWS) dy_next = YDW'(MAX_ROWS);
    else dy_next = YDW'(dim_y);
    dz_next = (dim_z == '0) ? DIM_Z_W'(1) : dim_z;
  end

  always_ff @(posedge clk) begin
    dx    <= dx_next;
    dy    <= dy_next;
    dz    <= dz_next;
    plane <= PDW'(PDW'(dx) * PDW'(dy));
    total <= TW'(plane) * TW'(dz);
    delay <= PSW'(plane) + PSW'(dx) + PSW'(1);
  end

  // input waits for the chain above to settle after a write or reset
  logic [1:0] settle;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= 2'd3;
    end else if (settle != '0) begin
      settle <= settle - 2'd1;
    end
  end

  // stage enable: the output register is free or being emptied
  logic en;
  assign en = !out_ch.valid || out_ch.ready;

  // positions and coordinates
  logic [PSW-1:0]     ip, op;
  logic [XAW-1:0]     ix;     // input column, row memory address
  logic [PAW-1:0]     pa;     // input index within plane, plane memory address
  logic [XAW-1:0]     cx;     // center voxel coordinates
  logic [YAW-1:0]     cy;
  logic [DIM_Z_W-1:0] cz;

  // a shrunken volume restarts the positions
  logic restart;
  assign restart = (settle == '0) && (op >= PSW'(total));

  assign in_ch.ready = en && !restart && (settle == '0);

  logic accept, is_data, in_vol, counted, emit, last;
  assign accept  = in_ch.valid && in_ch.ready;
  assign is_data = (in_ch.func == FUNC_VOXEL);
  assign in_vol  = ip < PSW'(total);
  // flush inside the volume is dropped without a trace
  assign counted = accept && !(in_vol && !is_data);
  assign emit    = ip >= (op + delay);
  assign last    = emit && ((op + PSW'(1)) == PSW'(total));

  always_ff @(posedge clk) begin
    if (rst || restart || (counted && last)) begin
      ip <= '0;
      op <= '0;
      ix <= '0;
      pa <= '0;
      cx <= '0;
      cy <= '0;
      cz <= '0;
    end else if (counted) begin
      ip <= ip + PSW'(1);
      ix <= ((XDW'(ix) + XDW'(1)) == dx) ? '0 : ix + XAW'(1);
      pa <= ((PDW'(pa) + PDW'(1)) == plane) ? '0 : pa + PAW'(1);
      if (emit) begin
        op <= op + PSW'(1);
        if ((XDW'(cx) + XDW'(1)) == dx) begin
          cx <= '0;
          if ((YDW'(cy) + YDW'(1)) == dy) begin
            cy <= '0;
            cz <= cz + DIM_Z_W'(1);
          end else begin
            cy <= cy + YAW'(1);
          end
        end else begin
          cx <= cx + XAW'(1);
        end
      end
    end
  end

  // neighbour masks around the center: index 0 ahead, 1 center, 2 behind
  logic [2:0]  mx, my, mz;
  logic [26:0] mask;

  always_comb begin
    mx = {cx != '0, 1'b1, (XDW'(cx) + XDW'(1)) < dx};
    my = {cy != '0, 1'b1, (YDW'(cy) + YDW'(1)) < dy};
    mz = {cz != '0, 1'b1, ((DIM_Z_W + 1)'(cz) + (DIM_Z_W + 1)'(1)) < (DIM_Z_W + 1)'(dz)};
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          mask[c*9 + k*3 + j] = mx[c] & mz[k] & my[j];
        end
      end
    end
  end

  // stage 1 registers
  logic           s1_valid, s1_flag, s1_emit, s1_last;
  logic [26:0]    s1_mask;
  logic [PAW-1:0] s1_pa;
  logic [XAW-1:0] s1_ix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= counted;
    end
    if (counted) begin
      s1_flag <= is_data && in_vol && (in_ch.voxel_word == on_value);
      s1_emit <= emit;
      s1_last <= last;
      s1_mask <= mask;
      s1_pa   <= pa;
      s1_ix   <= ix;
    end
  end

  // plane memory: {flag two planes back, flag one plane back} per position in the plane
  // row memory: {column two rows back, column one row back} per x
  logic [1:0] pmem [PDEPTH];
  logic [5:0] rmem [MAX_ROW];
  logic [1:0] pm_q, pm_last, p_rd, pm_wr;
  logic [5:0] rm_q, rm_last, r_rd, rm_wr;
  logic       wr_en;

  assign wr_en = en && s1_valid;

  always_ff @(posedge clk) begin
    if (counted) begin
      pm_q <= pmem[pa];
      rm_q <= rmem[ix];
    end
    if (wr_en) begin
      pmem[s1_pa] <= pm_wr;
      rmem[s1_ix] <= rm_wr;
      pm_last     <= pm_wr;
      rm_last     <= rm_wr;
    end
  end

  // a one-voxel plane or row revisits the same entry with the next item: forward
  logic [2:0]  col3;
  logic [8:0]  col9;
  logic [26:0] win, win_next;
  logic        edge_hit;

  always_comb begin
    p_rd  = (plane == PDW'(1)) ? pm_last : pm_q;
    r_rd  = (dx == XDW'(1)) ? rm_last : rm_q;
    col3  = {p_rd[1], p_rd[0], s1_flag};
    pm_wr = {p_rd[0], s1_flag};
    rm_wr = {r_rd[2:0], col3};
    for (int k = 0; k < 3; k++) begin
      col9[k*3 + 0] = col3[k];
      col9[k*3 + 1] = r_rd[k];
      col9[k*3 + 2] = r_rd[3 + k];
    end
    win_next = {win[17:0], col9};
    // center sits in the middle column, one plane and one row back
    edge_hit = win_next[13] && |(~win_next & s1_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (wr_en) begin
      win <= win_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= s1_valid && s1_emit;
    end
    if (en) begin
      out_ch.edge_word  <= edge_hit ? on_value : off_value;
      out_ch.last_voxel <= s1_last;
    end
  end

endmodule
